// ----- rtl/keyframe_vector_interpolator_top_assert.svh -----
// Assertion macros for the keyframe vector interpolator.
// Included by kvi_back, which checks its own control logic.
`ifndef KEYFRAME_VECTOR_INTERPOLATOR_TOP_ASSERT_SVH
`define KEYFRAME_VECTOR_INTERPOLATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define KVI_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define KVI_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define KVI_ASSERT_IMP(lbl, clk, rstn, a, c)
`define KVI_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

// ----- rtl/kvi_pkg.sv -----
// Shared types and constants of the keyframe vector interpolator.
// No dependencies.
package kvi_pkg;
    localparam int MAX_KEYS = 64;
    localparam int SLOT_W   = 6;
    localparam int TIME_W   = 24;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = 7;
    localparam int FRAC_W   = 16;
    localparam int QUO_W    = TIME_W + FRAC_W;

    typedef struct packed {
        logic                    operation;
        logic [SLOT_W-1:0]       key_slot;
        logic [TIME_W-1:0]       key_time;
        logic signed [VAL_W-1:0] value_x;
        logic signed [VAL_W-1:0] value_y;
        logic signed [VAL_W-1:0] value_z;
        logic [TIME_W-1:0]       query_tick;
    } in_word_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_x;
        logic signed [VAL_W-1:0] out_y;
        logic signed [VAL_W-1:0] out_z;
        logic                    saturated;
    } out_word_t;

    typedef struct packed {
        logic                       is_query;
        logic [SLOT_W-1:0]          slot;
        logic [TIME_W-1:0]          key_time;
        logic [2:0][VAL_W-1:0]      vec;
        logic [TIME_W-1:0]          tick;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;
endpackage

// ----- rtl/kvi_front.sv -----
// Input stage: accepts words and turns them into commands for the queue.
// Depends on kvi_pkg.
module kvi_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  kvi_pkg::in_word_t s_data,
    input  kvi_pkg::q_stat_t q_stat,
    output logic             q_push,
    output kvi_pkg::cmd_t    q_cmd
);
    logic          hold_valid_reg, hold_valid_next;
    kvi_pkg::cmd_t hold_cmd_reg;
    logic          s_acc;

    assign q_push  = hold_valid_reg && !q_stat.full;
    assign s_ready = !hold_valid_reg || !q_stat.full;
    assign s_acc   = s_valid && s_ready;
    assign q_cmd   = hold_cmd_reg;
    assign hold_valid_next = s_acc || (hold_valid_reg && !q_push);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            hold_cmd_reg.is_query <= s_data.operation;
            hold_cmd_reg.slot     <= s_data.key_slot;
            hold_cmd_reg.key_time <= s_data.key_time;
            hold_cmd_reg.vec      <= {s_data.value_z, s_data.value_y, s_data.value_x};
            hold_cmd_reg.tick     <= s_data.query_tick;
        end
    end
endmodule

// ----- rtl/kvi_queue.sv -----
// Two-entry command queue between the front and back stages.
// Depends on kvi_pkg.
module kvi_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  kvi_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output kvi_pkg::cmd_t    head_cmd,
    output kvi_pkg::q_stat_t stat
);
    kvi_pkg::cmd_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule

// ----- rtl/kvi_back.sv -----
// Execution stage: key tables, interval scan, divider and interpolation.
// Depends on kvi_pkg and keyframe_vector_interpolator_top_assert.svh.
`include "keyframe_vector_interpolator_top_assert.svh"
module kvi_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [kvi_pkg::CNT_W-1:0]    key_count,
    input  kvi_pkg::cmd_t                q_cmd,
    input  kvi_pkg::q_stat_t             q_stat,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output kvi_pkg::out_word_t           m_data
);
    localparam int SW = kvi_pkg::SLOT_W;
    localparam int TW = kvi_pkg::TIME_W;
    localparam int VW = kvi_pkg::VAL_W;
    localparam int CW = kvi_pkg::CNT_W;
    localparam int QW = kvi_pkg::QUO_W;
    localparam int FW = kvi_pkg::FRAC_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_F0   = 4'd2;
    localparam logic [3:0] S_F1   = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_ADD  = 4'd6;
    localparam logic [3:0] S_ONE  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [TW-1:0]       tmem [kvi_pkg::MAX_KEYS];
    logic [3*VW-1:0]     vmem [kvi_pkg::MAX_KEYS];
    logic [TW-1:0]       t_rd_reg;
    logic [3*VW-1:0]     v_rd_reg;
    logic [SW-1:0]       raddr;
    logic                mem_we;

    logic [3:0]          state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic [CW-1:0]       n_reg, n_next, n_clamp;
    logic [SW-1:0]       scan_i_reg, scan_i_next;
    logic [SW-1:0]       seg_reg, seg_next;
    logic [5:0]          div_cnt_reg, div_cnt_next;
    logic [1:0]          k_reg, k_next;

    logic [TW-1:0]       tick_reg, tick_next;
    logic [TW-1:0]       t0_reg, t0_next, t1_reg, t1_next;
    logic [2:0][VW-1:0]  v0_reg, v0_next, v1_reg, v1_next;
    logic [TW:0]         lm_reg, lm_next, rem_reg, rem_next;
    logic [QW-1:0]       dvd_reg, dvd_next, quo_reg, quo_next;
    logic                fneg_reg, fneg_next, dneg_reg, dneg_next;
    logic [56:0]         ph_reg, ph_next;
    logic [48:0]         pl_reg, pl_next;
    logic [2:0][VW-1:0]  res_reg, res_next;
    logic                sat_reg, sat_next;
    kvi_pkg::out_word_t  out_reg, out_next;

    logic signed [TW:0]  num_s, len_s;
    logic [TW:0]         nm, lm;
    logic [TW+1:0]       rem_sh;
    logic signed [VW:0]  diff;
    logic [VW:0]         dmag;
    logic [VW-1:0]       a_sel, b_sel;
    logic [57:0]         mag;
    logic signed [59:0]  delta, r_full;
    logic                out_load;

    always_comb begin
        if (key_count == '0) begin
            n_clamp = CW'(1);
        end else if (key_count > CW'(kvi_pkg::MAX_KEYS)) begin
            n_clamp = CW'(kvi_pkg::MAX_KEYS);
        end else begin
            n_clamp = key_count;
        end
        num_s  = $signed({1'b0, tick_reg}) - $signed({1'b0, t0_reg});
        len_s  = $signed({1'b0, t1_reg}) - $signed({1'b0, t0_reg});
        nm     = num_s[TW] ? TW'(-num_s) : TW'(num_s);
        lm     = len_s[TW] ? (TW+1)'(-len_s) : (TW+1)'(len_s);
        rem_sh = {rem_reg, dvd_reg[QW-1]};
        a_sel  = v0_reg[k_reg];
        b_sel  = v1_reg[k_reg];
        diff   = $signed({b_sel[VW-1], b_sel}) - $signed({a_sel[VW-1], a_sel});
        dmag   = diff[VW] ? (VW+1)'(-diff) : (VW+1)'(diff);
        mag    = 58'(ph_reg) + 58'((50'(pl_reg) + 50'h8000) >> FW);
        delta  = (dneg_reg != fneg_reg) ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        r_full = $signed({{28{a_sel[VW-1]}}, a_sel}) + delta;
    end

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        scan_i_next  = scan_i_reg;
        seg_next     = seg_reg;
        div_cnt_next = div_cnt_reg;
        k_next       = k_reg;
        tick_next    = tick_reg;
        t0_next      = t0_reg;
        t1_next      = t1_reg;
        v0_next      = v0_reg;
        v1_next      = v1_reg;
        lm_next      = lm_reg;
        rem_next     = rem_reg;
        dvd_next     = dvd_reg;
        quo_next     = quo_reg;
        fneg_next    = fneg_reg;
        dneg_next    = dneg_reg;
        ph_next      = ph_reg;
        pl_next      = pl_reg;
        res_next     = res_reg;
        sat_next     = sat_reg;
        out_next     = out_reg;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        raddr        = '0;
        out_load     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop = 1'b1;
                    if (!q_cmd.is_query) begin
                        mem_we = 1'b1;
                    end else begin
                        tick_next   = q_cmd.tick;
                        n_next      = n_clamp;
                        scan_i_next = '0;
                        if (n_clamp == CW'(1)) begin
                            raddr      = '0;
                            state_next = S_ONE;
                        end else begin
                            raddr      = SW'(1);
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (tick_reg < t_rd_reg || {1'b0, scan_i_reg} == n_reg - CW'(2)) begin
                    seg_next   = scan_i_reg;
                    t1_next    = t_rd_reg;
                    raddr      = scan_i_reg;
                    state_next = S_F0;
                end else begin
                    raddr       = scan_i_reg + SW'(2);
                    scan_i_next = scan_i_reg + SW'(1);
                end
            end
            S_F0: begin
                t0_next    = t_rd_reg;
                v0_next    = v_rd_reg;
                raddr      = seg_reg + SW'(1);
                state_next = S_F1;
            end
            S_F1: begin
                v1_next      = v_rd_reg;
                k_next       = '0;
                sat_next     = 1'b0;
                rem_next     = '0;
                div_cnt_next = '0;
                quo_next     = '0;
                if (len_s == '0) begin
                    fneg_next  = 1'b0;
                    state_next = S_MUL;
                end else begin
                    lm_next    = lm;
                    dvd_next   = {nm[TW-1:0], {FW{1'b0}}};
                    fneg_next  = num_s[TW] != len_s[TW];
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (rem_sh >= {1'b0, lm_reg}) begin
                    rem_next = (TW+1)'(rem_sh - {1'b0, lm_reg});
                    quo_next = {quo_reg[QW-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[TW:0];
                    quo_next = {quo_reg[QW-2:0], 1'b0};
                end
                dvd_next     = {dvd_reg[QW-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'(QW - 1)) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                ph_next    = 57'(dmag * quo_reg[QW-1:FW]);
                pl_next    = 49'(dmag * quo_reg[FW-1:0]);
                dneg_next  = diff[VW];
                state_next = S_ADD;
            end
            S_ADD: begin
                if (r_full > 60'sd2147483647) begin
                    res_next[k_reg] = 32'h7FFF_FFFF;
                    sat_next        = 1'b1;
                end else if (r_full < -60'sd2147483648) begin
                    res_next[k_reg] = 32'h8000_0000;
                    sat_next        = 1'b1;
                end else begin
                    res_next[k_reg] = r_full[VW-1:0];
                end
                if (k_reg == 2'd2) begin
                    state_next = S_OUT;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_ONE: begin
                res_next   = v_rd_reg;
                sat_next   = 1'b0;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_load           = 1'b1;
                    out_next.out_x     = res_reg[0];
                    out_next.out_y     = res_reg[1];
                    out_next.out_z     = res_reg[2];
                    out_next.saturated = sat_reg;
                    state_next         = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tmem[q_cmd.slot] <= q_cmd.key_time;
            vmem[q_cmd.slot] <= q_cmd.vec;
        end
        t_rd_reg <= tmem[raddr];
        v_rd_reg <= vmem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            n_reg         <= CW'(1);
            scan_i_reg    <= '0;
            seg_reg       <= '0;
            div_cnt_reg   <= '0;
            k_reg         <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            scan_i_reg    <= scan_i_next;
            seg_reg       <= seg_next;
            div_cnt_reg   <= div_cnt_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        tick_reg <= tick_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        v0_reg   <= v0_next;
        v1_reg   <= v1_next;
        lm_reg   <= lm_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
        fneg_reg <= fneg_next;
        dneg_reg <= dneg_next;
        ph_reg   <= ph_next;
        pl_reg   <= pl_next;
        res_reg  <= res_next;
        sat_reg  <= sat_next;
        out_reg  <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `KVI_ASSERT_IMP(a_scan_range, aclk, aresetn, state_reg == S_SCAN,
        {1'b0, scan_i_reg} <= n_reg - CW'(2))
    `KVI_ASSERT_NXT(a_div_end, aclk, aresetn,
        state_reg == S_DIV && div_cnt_reg == 6'(QW - 1), state_reg == S_MUL)
    `KVI_ASSERT_IMP(a_pop_idle, aclk, aresetn, q_pop, state_reg == S_IDLE && !q_stat.empty)
    `KVI_ASSERT_NXT(a_out_load, aclk, aresetn, out_load, m_valid && state_reg == S_IDLE)
endmodule

// ----- rtl/keyframe_vector_interpolator_top.sv -----
// A query with one key reads the stored vector and outputs it directly. Otherwise the
// key times are scanned one per cycle to find the interval, the two end keys are read,
// 40 divider steps run (skipped for an empty interval), and each vector component then
// passes through the multiply and add states on the shared multipliers.
// Throughput: key writes one per cycle while the back end is idle; a query holds it busy.
// Reset: key_count returns to 1, queue and result register empty; tables hold.
module keyframe_vector_interpolator_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  kvi_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output kvi_pkg::out_word_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    logic [kvi_pkg::CNT_W-1:0] key_count_reg;
    logic                      cfg_we;
    logic                      q_push, q_pop;
    kvi_pkg::cmd_t             push_cmd, head_cmd;
    kvi_pkg::q_stat_t          q_stat;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? 32'(key_count_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_count_reg <= kvi_pkg::CNT_W'(1);
        end else if (cfg_we) begin
            key_count_reg <= pwdata[kvi_pkg::CNT_W-1:0];
        end
    end

    kvi_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    kvi_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    kvi_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .key_count (key_count_reg),
        .q_cmd     (head_cmd),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );
endmodule
